/* hw/rtl/osa_pkg.sv */
package osa_pkg;

  localparam int COORD_W         = 32;
  localparam int RADIUS_W        = 31;
  localparam int SLOT_W          = 6;
  localparam int MAX_OBSTACLES_DEF = 64;

  // Steering numerator (steer_gain << 16) times a velocity magnitude.
  localparam int NUM_W           = 80;
  localparam int TERM_W          = 33;

  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 31;
  localparam int COUNT_W         = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_BODY_RADIUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_COUNT = 2'd2;

  localparam logic OPC_LOAD  = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  typedef struct packed {
    logic [RADIUS_W-1:0] body_radius;
    logic [RADIUS_W-1:0] steer_gain;
    logic [COUNT_W-1:0]  obstacle_count;
  } osa_cfg_t;

  // One queued request. A load uses f0..f2 for centre and radius,
  // a query uses f0..f5 for position, velocity and acceleration.
  typedef struct packed {
    logic               is_query;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] f0;
    logic [COORD_W-1:0] f1;
    logic [COORD_W-1:0] f2;
    logic [COORD_W-1:0] f3;
    logic [COORD_W-1:0] f4;
    logic [COORD_W-1:0] f5;
  } osa_item_t;

endpackage

/* hw/rtl/osa_if.sv */
interface osa_in_if import osa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [SLOT_W-1:0]          slot;
  logic signed [COORD_W-1:0]  obstacle_x;
  logic signed [COORD_W-1:0]  obstacle_y;
  logic [RADIUS_W-1:0]        obstacle_radius;
  logic signed [COORD_W-1:0]  char_x;
  logic signed [COORD_W-1:0]  char_y;
  logic signed [COORD_W-1:0]  vel_x;
  logic signed [COORD_W-1:0]  vel_y;
  logic signed [COORD_W-1:0]  accel_in_x;
  logic signed [COORD_W-1:0]  accel_in_y;

  modport source (output valid, opcode, slot, obstacle_x, obstacle_y, obstacle_radius,
                  char_x, char_y, vel_x, vel_y, accel_in_x, accel_in_y, input ready);
  modport sink (input valid, opcode, slot, obstacle_x, obstacle_y, obstacle_radius,
                char_x, char_y, vel_x, vel_y, accel_in_x, accel_in_y, output ready);
endinterface

interface osa_out_if import osa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  accel_out_x;
  logic signed [COORD_W-1:0]  accel_out_y;

  modport source (output valid, accel_out_x, accel_out_y, input ready);
  modport sink (input valid, accel_out_x, accel_out_y, output ready);
endinterface

/* hw/rtl/osa_ram.sv */
module osa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* hw/rtl/osa_front.sv */
module osa_front import osa_pkg::*; #(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  osa_in_if.sink    in_ch,
  output logic      q_valid,
  output osa_item_t q_item,
  input  logic      q_pop
);
  localparam int QD = 2;

  osa_item_t  q_mem_r [QD];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept, keep, push, pop;
  osa_item_t  item;

  assign in_ch.ready = (cnt_r != 2'(QD));
  assign accept = in_ch.valid && in_ch.ready;
  // Loads aimed past the end of the table are taken and dropped here.
  assign keep = (in_ch.opcode == OPC_QUERY) ||
                ({26'd0, in_ch.slot} < 32'(MAX_OBSTACLES));
  assign push = accept && keep;
  assign pop  = q_pop && (cnt_r != 2'd0);

  always_comb begin
    item.is_query = (in_ch.opcode == OPC_QUERY);
    item.slot     = in_ch.slot;
    if (in_ch.opcode == OPC_QUERY) begin
      item.f0 = in_ch.char_x;
      item.f1 = in_ch.char_y;
      item.f2 = in_ch.vel_x;
    end else begin
      item.f0 = in_ch.obstacle_x;
      item.f1 = in_ch.obstacle_y;
      item.f2 = {1'b0, in_ch.obstacle_radius};
    end
    item.f3 = in_ch.vel_y;
    item.f4 = in_ch.accel_in_x;
    item.f5 = in_ch.accel_in_y;
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= item;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_mem_r[rp_r];
endmodule

/* hw/rtl/osa_mul.sv */
module osa_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] p
);
  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   step_r;
  logic         busy_r, done_r;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [6:0]   shamt;

  // One 32x32 partial product per cycle, four partial products per 64-bit product.
  always_comb begin
    ah      = step_r[1] ? a_r[63:32] : a_r[31:0];
    bh      = step_r[0] ? b_r[63:32] : b_r[31:0];
    pp      = ah * bh;
    shamt   = {step_r[1] & step_r[0], step_r[1] ^ step_r[0], 5'd0};
    acc_nxt = acc_r + ({64'd0, pp} << shamt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

/* hw/rtl/osa_div.sv */
module osa_div import osa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  n_x,
  input  logic [NUM_W-1:0]  n_y,
  input  logic [63:0]       d,
  output logic              done,
  output logic [TERM_W-1:0] q_x,
  output logic [TERM_W-1:0] q_y
);
  localparam int CW = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] CAP = NUM_W'(64'h1_0000_0000);

  logic [NUM_W-1:0] nx_r, ny_r, qx_r, qy_r;
  logic [64:0]      rx_r, ry_r;
  logic [63:0]      d_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [64:0]      rx_sh, ry_sh;
  logic             gex, gey;

  // Restoring division, one quotient bit per lane and cycle.
  always_comb begin
    rx_sh = {rx_r[63:0], nx_r[NUM_W-1]};
    ry_sh = {ry_r[63:0], ny_r[NUM_W-1]};
    gex   = (rx_sh >= {1'b0, d_r});
    gey   = (ry_sh >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nx_r <= n_x;
      ny_r <= n_y;
      d_r  <= d;
      rx_r <= '0;
      ry_r <= '0;
      qx_r <= '0;
      qy_r <= '0;
    end else if (busy_r) begin
      nx_r <= nx_r << 1;
      ny_r <= ny_r << 1;
      rx_r <= gex ? rx_sh - {1'b0, d_r} : rx_sh;
      ry_r <= gey ? ry_sh - {1'b0, d_r} : ry_sh;
      qx_r <= {qx_r[NUM_W-2:0], gex};
      qy_r <= {qy_r[NUM_W-2:0], gey};
    end
  end

  assign done = done_r;
  assign q_x  = (qx_r > CAP) ? CAP[TERM_W-1:0] : qx_r[TERM_W-1:0];
  assign q_y  = (qy_r > CAP) ? CAP[TERM_W-1:0] : qy_r[TERM_W-1:0];
endmodule

/* hw/rtl/osa_back.sv */
module osa_back import osa_pkg::*; #(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  osa_cfg_t  cfg,
  input  logic      q_valid,
  input  osa_item_t q_item,
  output logic      q_pop,
  osa_out_if.source out_ch
);
  localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int NW = ($clog2(MAX_OBSTACLES + 1) > COUNT_W) ?
                      $clog2(MAX_OBSTACLES + 1) : COUNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MST  = 4'd1;
  localparam logic [3:0] S_MWT  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_LAT  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_DST  = 4'd6;
  localparam logic [3:0] S_DWT  = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;
  localparam logic [3:0] S_NEXT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  localparam logic [3:0] OP_VXX = 4'd0;
  localparam logic [3:0] OP_VYY = 4'd1;
  localparam logic [3:0] OP_NX  = 4'd2;
  localparam logic [3:0] OP_NY  = 4'd3;
  localparam logic [3:0] OP_P1  = 4'd4;
  localparam logic [3:0] OP_P2  = 4'd5;
  localparam logic [3:0] OP_P3  = 4'd6;
  localparam logic [3:0] OP_P4  = 4'd7;
  localparam logic [3:0] OP_RR  = 4'd8;
  localparam logic [3:0] OP_CC  = 4'd9;
  localparam logic [3:0] OP_RS  = 4'd10;

  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a,
    input logic [TERM_W-1:0]         t,
    input logic                      neg
  );
    logic signed [34:0] tv;
    logic signed [34:0] s;
    tv = neg ? -$signed({2'b00, t}) : $signed({2'b00, t});
    s  = $signed({{3{a[COORD_W-1]}}, a}) + tv;
    if (s > 35'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return s[COORD_W-1:0];
  endfunction

  logic [3:0]   state_r, op_r;
  logic [NW-1:0] idx_r, n_r, n_w;
  logic signed [COORD_W-1:0] px_r, py_r, acc_x_r, acc_y_r;
  logic [COORD_W-1:0] avx_r, avy_r, arx_r, ary_r;
  logic         vxn_r, vyn_r, vxpos_r, rxn_r, ryn_r, cneg_r;
  logic [32:0]  rad_r;
  logic [63:0]  vxx_r, spd_r, rr_r, cmag_r;
  logic [NUM_W-1:0] numx_r, numy_r;
  logic signed [64:0] p1s_r, p2s_r, p3s_r, p4s_r;
  logic [127:0] cc_r;
  logic         out_valid_r;
  logic signed [COORD_W-1:0] ox_r, oy_r;

  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] mul_p;
  logic         div_start, div_done;
  logic [TERM_W-1:0] tx, ty;

  logic [COORD_W-1:0]  cx_rd, cy_rd;
  logic [RADIUS_W-1:0] r_rd;
  logic         ram_we;

  logic signed [32:0] rx_w, ry_w, nrx_w, nry_w;
  logic signed [65:0] c_w, nc_w, dot_w;
  logic         psign;
  logic [64:0]  pmag;
  logic signed [64:0] ps_w;
  logic signed [COORD_W-1:0] qvx, qvy, nvx, nvy;

  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign ram_we = q_pop && !q_item.is_query;

  osa_ram #(.WIDTH(COORD_W), .DEPTH(MAX_OBSTACLES)) u_ram_x (
    .clk(clk), .we(ram_we), .waddr(AW'(q_item.slot)), .wdata(q_item.f0),
    .raddr(idx_r[AW-1:0]), .rdata(cx_rd)
  );
  osa_ram #(.WIDTH(COORD_W), .DEPTH(MAX_OBSTACLES)) u_ram_y (
    .clk(clk), .we(ram_we), .waddr(AW'(q_item.slot)), .wdata(q_item.f1),
    .raddr(idx_r[AW-1:0]), .rdata(cy_rd)
  );
  osa_ram #(.WIDTH(RADIUS_W), .DEPTH(MAX_OBSTACLES)) u_ram_r (
    .clk(clk), .we(ram_we), .waddr(AW'(q_item.slot)), .wdata(q_item.f2[RADIUS_W-1:0]),
    .raddr(idx_r[AW-1:0]), .rdata(r_rd)
  );

  osa_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  osa_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .n_x(numx_r), .n_y(numy_r),
    .d(cmag_r), .done(div_done), .q_x(tx), .q_y(ty)
  );

  assign mul_start = (state_r == S_MST);
  assign div_start = (state_r == S_DST);

  always_comb begin
    case (op_r)
      OP_VXX:  begin mul_a = 64'(avx_r); mul_b = 64'(avx_r); end
      OP_VYY:  begin mul_a = 64'(avy_r); mul_b = 64'(avy_r); end
      OP_NX:   begin mul_a = 64'({cfg.steer_gain, 16'd0}); mul_b = 64'(avy_r); end
      OP_NY:   begin mul_a = 64'({cfg.steer_gain, 16'd0}); mul_b = 64'(avx_r); end
      OP_P1:   begin mul_a = 64'(avx_r); mul_b = 64'(ary_r); end
      OP_P2:   begin mul_a = 64'(avy_r); mul_b = 64'(arx_r); end
      OP_P3:   begin mul_a = 64'(avx_r); mul_b = 64'(arx_r); end
      OP_P4:   begin mul_a = 64'(avy_r); mul_b = 64'(ary_r); end
      OP_RR:   begin mul_a = 64'(rad_r); mul_b = 64'(rad_r); end
      OP_CC:   begin mul_a = cmag_r;     mul_b = cmag_r; end
      OP_RS:   begin mul_a = rr_r;       mul_b = spd_r; end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  // Sign of the current offset product, from the signs of its two factors.
  always_comb begin
    case (op_r)
      OP_P1:   psign = vxn_r ^ ryn_r;
      OP_P2:   psign = vyn_r ^ rxn_r;
      OP_P3:   psign = vxn_r ^ rxn_r;
      OP_P4:   psign = vyn_r ^ ryn_r;
      default: psign = 1'b0;
    endcase
    pmag = {1'b0, mul_p[63:0]};
    ps_w = psign ? -$signed(pmag) : $signed(pmag);
  end

  always_comb begin
    rx_w  = $signed({cx_rd[COORD_W-1], cx_rd}) - $signed({px_r[COORD_W-1], px_r});
    ry_w  = $signed({cy_rd[COORD_W-1], cy_rd}) - $signed({py_r[COORD_W-1], py_r});
    nrx_w = -rx_w;
    nry_w = -ry_w;
    c_w   = $signed({p1s_r[64], p1s_r}) - $signed({p2s_r[64], p2s_r});
    nc_w  = -c_w;
    dot_w = $signed({p3s_r[64], p3s_r}) + $signed({p4s_r[64], p4s_r});
    qvx   = $signed(q_item.f2);
    qvy   = $signed(q_item.f3);
    nvx   = -qvx;
    nvy   = -qvy;
    n_w   = (NW'(cfg.obstacle_count) > NW'(MAX_OBSTACLES)) ?
            NW'(MAX_OBSTACLES) : NW'(cfg.obstacle_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_VXX;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_item.is_query) begin
            op_r    <= OP_VXX;
            state_r <= S_MST;
          end
        end
        S_MST: state_r <= S_MWT;
        S_MWT: begin
          if (mul_done) begin
            case (op_r)
              OP_VXX: begin op_r <= OP_VYY; state_r <= S_MST; end
              OP_VYY: begin op_r <= OP_NX;  state_r <= S_MST; end
              OP_NX:  begin op_r <= OP_NY;  state_r <= S_MST; end
              OP_NY: begin
                idx_r   <= '0;
                state_r <= (n_r == '0) ? S_DONE : S_RD;
              end
              OP_P1:  begin op_r <= OP_P2; state_r <= S_MST; end
              OP_P2:  begin op_r <= OP_P3; state_r <= S_MST; end
              OP_P3:  begin op_r <= OP_P4; state_r <= S_MST; end
              OP_P4:  begin op_r <= OP_RR; state_r <= S_MST; end
              OP_RR:  state_r <= S_CHK;
              OP_CC:  begin op_r <= OP_RS; state_r <= S_MST; end
              OP_RS:  state_r <= (cc_r < mul_p) ? S_DST : S_NEXT;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_RD:  state_r <= S_LAT;
        S_LAT: begin
          op_r    <= OP_P1;
          state_r <= S_MST;
        end
        S_CHK: begin
          // Skip obstacles behind the character or centred on its line of motion.
          if (dot_w[65] || (dot_w == '0) || (c_w == '0)) begin
            state_r <= S_NEXT;
          end else begin
            op_r    <= OP_CC;
            state_r <= S_MST;
          end
        end
        S_DST: state_r <= S_DWT;
        S_DWT: begin
          if (div_done) begin
            state_r <= S_ACC;
          end
        end
        S_ACC:  state_r <= S_NEXT;
        S_NEXT: begin
          if ((idx_r + NW'(1)) == n_r) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + NW'(1);
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.is_query) begin
      px_r    <= $signed(q_item.f0);
      py_r    <= $signed(q_item.f1);
      acc_x_r <= $signed(q_item.f4);
      acc_y_r <= $signed(q_item.f5);
      vxn_r   <= qvx[COORD_W-1];
      vyn_r   <= qvy[COORD_W-1];
      vxpos_r <= !qvx[COORD_W-1] && (qvx != '0);
      avx_r   <= qvx[COORD_W-1] ? nvx : qvx;
      avy_r   <= qvy[COORD_W-1] ? nvy : qvy;
      n_r     <= n_w;
    end
    if ((state_r == S_MWT) && mul_done) begin
      case (op_r)
        OP_VXX:  vxx_r  <= mul_p[63:0];
        OP_VYY:  spd_r  <= vxx_r + mul_p[63:0];
        OP_NX:   numx_r <= mul_p[NUM_W-1:0];
        OP_NY:   numy_r <= mul_p[NUM_W-1:0];
        OP_P1:   p1s_r  <= ps_w;
        OP_P2:   p2s_r  <= ps_w;
        OP_P3:   p3s_r  <= ps_w;
        OP_P4:   p4s_r  <= ps_w;
        OP_RR:   rr_r   <= mul_p[63:0];
        OP_CC:   cc_r   <= mul_p;
        default: ;
      endcase
    end
    if (state_r == S_LAT) begin
      rxn_r <= rx_w[32];
      ryn_r <= ry_w[32];
      arx_r <= rx_w[32] ? nrx_w[31:0] : rx_w[31:0];
      ary_r <= ry_w[32] ? nry_w[31:0] : ry_w[31:0];
      rad_r <= 33'(r_rd) + 33'(cfg.body_radius);
    end
    if (state_r == S_CHK) begin
      cneg_r <= c_w[65];
      cmag_r <= c_w[65] ? nc_w[63:0] : c_w[63:0];
    end
    if (state_r == S_ACC) begin
      acc_x_r <= sat_add(acc_x_r, tx, vyn_r != cneg_r);
      acc_y_r <= sat_add(acc_y_r, ty, vxpos_r != cneg_r);
    end
    if ((state_r == S_DONE) && (!out_valid_r || out_ch.ready)) begin
      ox_r <= acc_x_r;
      oy_r <= acc_y_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accel_out_x = ox_r;
  assign out_ch.accel_out_y = oy_r;
endmodule

/* hw/rtl/obstacle_avoidance_steering.sv */
// A load is written to the obstacle table as it leaves the queue. A query runs a setup,
// then takes each obstacle in turn, shortest for one behind the character or on its line
// of motion, longer for one passing wide, longest for one hit. One query runs at a time.
// The shared 32x32 multiplier and the one-bit-per-cycle divider set these path lengths;
// a two-entry queue keeps the input accepting while a query runs, until it fills.
// Synchronous reset (rst_n low) empties the queue, idles the sequencer and clears the config.
module obstacle_avoidance_steering import osa_pkg::*; #(
  parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  osa_in_if.sink                in_ch,
  osa_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  osa_cfg_t  cfg_r;
  logic      q_valid, q_pop;
  osa_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BODY_RADIUS:    cfg_r.body_radius    <= cfg_wdata;
        CFG_STEER_GAIN:     cfg_r.steer_gain     <= cfg_wdata;
        CFG_OBSTACLE_COUNT: cfg_r.obstacle_count <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  osa_front #(.MAX_OBSTACLES(MAX_OBSTACLES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  osa_back #(.MAX_OBSTACLES(MAX_OBSTACLES)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule

/* hw/rtl/osa_checker.sv */
module osa_checker import osa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] accel_out_x,
  input logic [COORD_W-1:0] accel_out_y
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(accel_out_x) && $stable(accel_out_y))
    else $error("stalled result changed");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");
endmodule

bind obstacle_avoidance_steering osa_checker u_osa_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .accel_out_x(out_ch.accel_out_x), .accel_out_y(out_ch.accel_out_y)
);
